/* rtl/acc_pkg.sv */
// Shared types, opcodes and constants for the accumulator CPU core.
// Used by the controller, datapath and top level; no dependencies.
package acc_pkg;

	localparam int MEM_DEPTH_DEF = 256;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] addr;
		logic [7:0] wdata;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] acc;
		logic [7:0] data_store;
		logic [7:0] mem_pointer;
		logic [7:0] prog_counter;
		logic       running;
	} rsp_t;

	localparam logic [1:0] FN_WRITE = 2'd0;
	localparam logic [1:0] FN_READ  = 2'd1;
	localparam logic [1:0] FN_EXEC  = 2'd2;
	localparam logic [1:0] FN_RST   = 2'd3;

	localparam logic [7:0] OP_LD = 8'd0, OP_SAV = 8'd1, OP_SWP = 8'd2, OP_ADD = 8'd3,
		OP_SUB = 8'd4, OP_MUL = 8'd5, OP_DIV = 8'd6, OP_AND = 8'd7, OP_OR = 8'd8,
		OP_XOR = 8'd9, OP_INV = 8'd10, OP_LSH = 8'd11, OP_RSH = 8'd12, OP_JMP = 8'd13,
		OP_JEZ = 8'd14, OP_JNZ = 8'd15, OP_MINC = 8'd16, OP_MDEC = 8'd17,
		OP_MSET = 8'd18, OP_READ = 8'd19, OP_WRITE = 8'd20, OP_HLT = 8'd21,
		OP_LDM = 8'd22, OP_SAVM = 8'd23, OP_SWPM = 8'd24, OP_ADDM = 8'd25,
		OP_SUBM = 8'd26, OP_MULM = 8'd27, OP_DIVM = 8'd28, OP_ANDM = 8'd29,
		OP_ORM = 8'd30, OP_XORM = 8'd31, OP_LSHM = 8'd32, OP_RSHM = 8'd33,
		OP_JMPM = 8'd34, OP_JEZM = 8'd35, OP_JNZM = 8'd36;

	// memory address source
	localparam logic [1:0] MA_REQ = 2'd0, MA_PC = 2'd1, MA_OPND = 2'd2, MA_PTR = 2'd3;

	// accumulator/register update selects
	localparam logic [3:0] AU_NONE = 4'd0, AU_MEM = 4'd1, AU_ALU = 4'd2, AU_SWP = 4'd3,
		AU_INV = 4'd4, AU_DIV = 4'd5, AU_PINC = 4'd6, AU_PDEC = 4'd7, AU_PSET = 4'd8,
		AU_SAV = 4'd9, AU_PCMEM = 4'd10, AU_PCOPND = 4'd11;

	// ALU ops (immediate opcode numbering minus offset)
	localparam logic [2:0] AL_ADD = 3'd0, AL_SUB = 3'd1, AL_MUL = 3'd2, AL_AND = 3'd3,
		AL_OR = 3'd4, AL_XOR = 3'd5, AL_LSH = 3'd6, AL_RSH = 3'd7;

	typedef struct packed {
		logic       mem_rd;     // registered read at selected address
		logic       mem_wr;     // write acc or wdata
		logic       wr_req;     // write data from request
		logic [1:0] ma_sel;
		logic       pc_inc;
		logic       opnd_ld;    // latch read byte + start as operand address
		logic       op_ld;      // latch read byte as opcode
		logic [3:0] upd;
		logic [2:0] alu_op;
		logic       div_start;
		logic       halt;
		logic       restart;
		logic       rd_out;     // latch read byte into read_data
		logic       rd_clr;
	} cmd_t;

	typedef struct packed {
		logic [7:0] opcode;
		logic       acc_zero;
		logic       div_done;
		logic       running;
	} sts_t;

endpackage

/* rtl/acc_datapath.sv */
// Datapath: memory, register file, ALU and a restoring divider.
// Depends on acc_pkg; driven by acc_ctrl commands.
module acc_datapath #(
	parameter int MEM_DEPTH = acc_pkg::MEM_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  acc_pkg::cmd_t  cmd,
	input  acc_pkg::req_t  req,
	input  logic [7:0]     start_address,
	output acc_pkg::sts_t  sts,
	output acc_pkg::rsp_t  regs
);
	localparam int AW = $clog2(MEM_DEPTH);

	logic [7:0] mem [MEM_DEPTH];
	logic [7:0] acc_q, sec_q, ptr_q, pc_q, op_q, opnd_q, rd_q, rdout_q;
	logic       run_q;
	logic [7:0] ma;
	logic [AW-1:0] idx;
	logic [7:0] alu_y;
	logic [15:0] prod;
	logic [7:0] quo_q, rem_q, dvs_q;
	logic [3:0] dcnt_q;
	logic [8:0] trial;

	// clear pass state
	logic [AW:0] clr_q;

	always_comb begin
		case (cmd.ma_sel)
			acc_pkg::MA_REQ:  ma = req.addr;
			acc_pkg::MA_PC:   ma = pc_q;
			acc_pkg::MA_OPND: ma = opnd_q;
			default:          ma = ptr_q;
		endcase
	end
	assign idx = ma[AW-1:0];

	// memory: clear after reset, then one read or write per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (clr_q < (AW+1)'(MEM_DEPTH)) clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (clr_q < (AW+1)'(MEM_DEPTH)) mem[clr_q[AW-1:0]] <= 8'd0;
		else if (cmd.mem_wr) mem[idx] <= cmd.wr_req ? req.wdata : acc_q;
		if (cmd.mem_rd) rd_q <= mem[idx];
	end

	assign prod = acc_q * rd_q;

	always_comb begin
		case (cmd.alu_op)
			acc_pkg::AL_ADD: alu_y = acc_q + rd_q;
			acc_pkg::AL_SUB: alu_y = acc_q - rd_q;
			acc_pkg::AL_MUL: alu_y = prod[7:0];
			acc_pkg::AL_AND: alu_y = acc_q & rd_q;
			acc_pkg::AL_OR:  alu_y = acc_q | rd_q;
			acc_pkg::AL_XOR: alu_y = acc_q ^ rd_q;
			acc_pkg::AL_LSH: alu_y = (rd_q >= 8'd8) ? 8'd0 : (acc_q << rd_q[2:0]);
			default:         alu_y = (rd_q >= 8'd8) ? 8'd0 : (acc_q >> rd_q[2:0]);
		endcase
	end

	// restoring divider, one quotient bit per cycle
	assign trial = {rem_q, quo_q[7]} - {1'b0, dvs_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cmd.div_start) dcnt_q <= 4'd8;
		else if (dcnt_q != 4'd0) dcnt_q <= dcnt_q - 1'b1;
	end
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= acc_q; rem_q <= 8'd0; dvs_q <= rd_q;
		end else if (dcnt_q != 4'd0) begin
			if (!trial[8]) begin
				rem_q <= trial[7:0]; quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= {rem_q[6:0], quo_q[7]}; quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	// architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0; sec_q <= '0; ptr_q <= '0; pc_q <= '0; run_q <= 1'b1;
			op_q <= '0; opnd_q <= '0; rdout_q <= '0;
		end else begin
			if (cmd.pc_inc) pc_q <= pc_q + 8'd1;
			if (cmd.op_ld) op_q <= rd_q;
			if (cmd.opnd_ld) opnd_q <= rd_q + start_address;
			if (cmd.halt) run_q <= 1'b0;
			if (cmd.restart) begin pc_q <= start_address; run_q <= 1'b1; end
			if (cmd.rd_out) rdout_q <= rd_q;
			if (cmd.rd_clr) rdout_q <= 8'd0;
			case (cmd.upd)
				acc_pkg::AU_MEM:    acc_q <= rd_q;
				acc_pkg::AU_ALU:    acc_q <= alu_y;
				acc_pkg::AU_SWP:    begin acc_q <= sec_q; sec_q <= acc_q; end
				acc_pkg::AU_INV:    acc_q <= ~acc_q;
				acc_pkg::AU_DIV:    acc_q <= (dvs_q == 8'd0) ? 8'hFF : quo_q;
				acc_pkg::AU_PINC:   ptr_q <= ptr_q + acc_q;
				acc_pkg::AU_PDEC:   ptr_q <= ptr_q - acc_q;
				acc_pkg::AU_PSET:   ptr_q <= acc_q;
				acc_pkg::AU_SAV:    sec_q <= acc_q;
				acc_pkg::AU_PCMEM:  pc_q <= rd_q;
				acc_pkg::AU_PCOPND: pc_q <= opnd_q;
				default: ;
			endcase
		end
	end

	assign sts.opcode   = op_q;
	assign sts.acc_zero = (acc_q == 8'd0);
	assign sts.div_done = (dcnt_q == 4'd0) && !cmd.div_start;
	assign sts.running  = run_q && (clr_q == (AW+1)'(MEM_DEPTH));

	assign regs.read_data    = rdout_q;
	assign regs.acc          = acc_q;
	assign regs.data_store   = sec_q;
	assign regs.mem_pointer  = ptr_q;
	assign regs.prog_counter = pc_q;
	assign regs.running      = run_q;

	// memory clear finishes once and never restarts
	assert property (@(posedge clk) disable iff (!arst_n)
		(clr_q == (AW+1)'(MEM_DEPTH)) |=> (clr_q == (AW+1)'(MEM_DEPTH)))
		else $error("clear pass restarted");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (dcnt_q == 4'd8)) else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.halt |=> !run_q) else $error("halt not taken");
endmodule

/* rtl/acc_ctrl.sv */
// Sequencer: handshake, fetch, operand fetch, execute and result stage.
// Depends on acc_pkg; commands acc_datapath.
module acc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  acc_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	input  logic          busy_clr,
	input  acc_pkg::sts_t sts,
	output acc_pkg::cmd_t cmd
);
	localparam logic [3:0] S_IDLE = 4'd0, S_ACC = 4'd1, S_OP = 4'd2, S_DEC = 4'd3,
		S_IMM = 4'd4, S_OPA = 4'd5, S_MEM = 4'd6, S_EXE = 4'd7, S_DIV = 4'd8,
		S_OUT = 4'd9, S_RD = 4'd10;

	logic [3:0] st_q, st_d;
	logic [7:0] op;
	logic       ovld_q;
	logic       imm, mem_form, uses_opnd, alu_imm;

	assign op = sts.opcode;
	assign in_ready = (st_q == S_IDLE) && !busy_clr && (!ovld_q || out_ready);
	assign out_valid = ovld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovld_q <= 1'b0;
		else if (st_q == S_OUT) ovld_q <= 1'b1;
		else if (out_ready) ovld_q <= 1'b0;
	end

	// opcode classes
	always_comb begin
		alu_imm  = (op >= acc_pkg::OP_ADD && op <= acc_pkg::OP_RSH && op != acc_pkg::OP_INV);
		imm      = (op == acc_pkg::OP_LD) || alu_imm;
		mem_form = (op >= acc_pkg::OP_LDM && op <= acc_pkg::OP_JNZM);
		uses_opnd = mem_form || (op >= acc_pkg::OP_JMP && op <= acc_pkg::OP_JNZ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= S_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		cmd = '0;
		st_d = st_q;
		case (st_q)
			S_IDLE: if (in_valid && in_ready) begin
				cmd.rd_clr = 1'b1;
				st_d = S_OUT;
				case (in_data.func)
					acc_pkg::FN_WRITE: begin
						cmd.mem_wr = 1'b1; cmd.wr_req = 1'b1; cmd.ma_sel = acc_pkg::MA_REQ;
					end
					acc_pkg::FN_READ: begin
						cmd.mem_rd = 1'b1; cmd.ma_sel = acc_pkg::MA_REQ; st_d = S_RD;
					end
					acc_pkg::FN_EXEC: if (sts.running) begin
						cmd.mem_rd = 1'b1; cmd.ma_sel = acc_pkg::MA_PC; cmd.pc_inc = 1'b1;
						st_d = S_OP;
					end
					default: cmd.restart = 1'b1;
				endcase
			end
			S_RD: begin cmd.rd_out = 1'b1; st_d = S_OUT; end
			S_OP: begin cmd.op_ld = 1'b1; st_d = S_DEC; end
			S_DEC: begin
				if (imm || uses_opnd) begin
					cmd.mem_rd = 1'b1; cmd.ma_sel = acc_pkg::MA_PC; cmd.pc_inc = 1'b1;
					st_d = imm ? S_IMM : S_OPA;
				end else begin
					st_d = S_OUT;
					case (op)
						acc_pkg::OP_SAV:   cmd.upd = acc_pkg::AU_SAV;
						acc_pkg::OP_SWP:   cmd.upd = acc_pkg::AU_SWP;
						acc_pkg::OP_INV:   cmd.upd = acc_pkg::AU_INV;
						acc_pkg::OP_MINC:  cmd.upd = acc_pkg::AU_PINC;
						acc_pkg::OP_MDEC:  cmd.upd = acc_pkg::AU_PDEC;
						acc_pkg::OP_MSET:  cmd.upd = acc_pkg::AU_PSET;
						acc_pkg::OP_READ: begin
							cmd.mem_rd = 1'b1; cmd.ma_sel = acc_pkg::MA_PTR; st_d = S_MEM;
						end
						acc_pkg::OP_WRITE: begin
							cmd.mem_wr = 1'b1; cmd.ma_sel = acc_pkg::MA_PTR;
						end
						default: cmd.halt = 1'b1;
					endcase
				end
			end
			S_IMM: begin
				st_d = S_OUT;
				if (op == acc_pkg::OP_LD) cmd.upd = acc_pkg::AU_MEM;
				else if (op == acc_pkg::OP_DIV) begin cmd.div_start = 1'b1; st_d = S_DIV; end
				else begin
					cmd.upd = acc_pkg::AU_ALU;
					// skip the DIV and INV slots of the opcode numbering
					cmd.alu_op = (op >= acc_pkg::OP_LSH) ? 3'(op - 8'd5) :
						(op >= acc_pkg::OP_AND) ? 3'(op - 8'd4) : 3'(op - 8'd3);
				end
			end
			S_OPA: begin cmd.opnd_ld = 1'b1; st_d = S_EXE; end
			S_EXE: begin
				st_d = S_OUT;
				case (op)
					acc_pkg::OP_JMP: cmd.upd = acc_pkg::AU_PCOPND;
					acc_pkg::OP_JEZ: if (sts.acc_zero) cmd.upd = acc_pkg::AU_PCOPND;
					acc_pkg::OP_JNZ: if (!sts.acc_zero) cmd.upd = acc_pkg::AU_PCOPND;
					acc_pkg::OP_SAVM: begin cmd.mem_wr = 1'b1; cmd.ma_sel = acc_pkg::MA_OPND; end
					default: begin
						cmd.mem_rd = 1'b1; cmd.ma_sel = acc_pkg::MA_OPND; st_d = S_MEM;
					end
				endcase
			end
			S_MEM: begin
				st_d = S_OUT;
				case (op)
					acc_pkg::OP_READ, acc_pkg::OP_LDM: cmd.upd = acc_pkg::AU_MEM;
					acc_pkg::OP_SWPM: begin
						cmd.upd = acc_pkg::AU_MEM; cmd.mem_wr = 1'b1; cmd.ma_sel = acc_pkg::MA_OPND;
					end
					acc_pkg::OP_DIVM: begin cmd.div_start = 1'b1; st_d = S_DIV; end
					acc_pkg::OP_JMPM: cmd.upd = acc_pkg::AU_PCMEM;
					acc_pkg::OP_JEZM: if (sts.acc_zero) cmd.upd = acc_pkg::AU_PCMEM;
					acc_pkg::OP_JNZM: if (!sts.acc_zero) cmd.upd = acc_pkg::AU_PCMEM;
					default: begin
						cmd.upd = acc_pkg::AU_ALU;
						// skip the DIV_M slot of the opcode numbering
						cmd.alu_op = (op >= acc_pkg::OP_ANDM) ? 3'(op - 8'd26) : 3'(op - 8'd25);
					end
				endcase
			end
			S_DIV: if (sts.div_done) begin cmd.upd = acc_pkg::AU_DIV; st_d = S_OUT; end
			S_OUT: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	// results are only raised after the work is done
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_OUT) |=> out_valid) else $error("result not raised");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (st_q != S_IDLE)) else $error("request lost");
endmodule

/* rtl/accumulator_cpu_core.sv */
// Accumulator CPU core top level: sequencer plus datapath.
// Depends on acc_pkg, acc_ctrl and acc_datapath.
// Every memory access goes through the single memory port.
// One request at a time; the next is taken once the result register frees.
// Reset clears registers, sets running, then clears every memory location.
module accumulator_cpu_core #(
	parameter int MEM_DEPTH = acc_pkg::MEM_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  acc_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output acc_pkg::rsp_t out_data,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata
);
	logic [7:0]    start_q;
	acc_pkg::cmd_t cmd;
	acc_pkg::sts_t sts;
	logic          busy_clr;

	// hold program base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_q <= '0;
		else if (cfg_we) start_q <= cfg_wdata;
	end

	assign busy_clr = !sts.running && out_data.running;

	acc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
		.busy_clr, .sts, .cmd
	);

	acc_datapath #(.MEM_DEPTH(MEM_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .req(in_data), .start_address(start_q), .sts,
		.regs(out_data)
	);
endmodule

/* sim/tb_top.sv */
// Self-checking testbench for accumulator_cpu_core: drives memory, execute and
// restart requests, predicts each response, and checks it. Depends on acc_pkg.
`timescale 1ns / 1ps

module tb_top;

	// Tracks CPU state and queues the expected responses
	class cpu_scoreboard;
		logic [7:0] mem [256];
		logic [7:0] acc, dreg, ptr, pc, base;
		logic       run;
		acc_pkg::rsp_t pending [$];
		int         errors;

		function new();
			foreach (mem[i]) mem[i] = 8'd0;
			acc = 8'd0; dreg = 8'd0; ptr = 8'd0; pc = 8'd0; base = 8'd0;
			run = 1'b1; errors = 0;
		endfunction

		function logic [7:0] fetch_byte();
			logic [7:0] v;
			v = mem[pc];
			pc = pc + 8'd1;
			return v;
		endfunction

		function logic [7:0] alu_result(logic [7:0] op, logic [7:0] a, logic [7:0] b);
			case (op)
				acc_pkg::OP_ADD: return a + b;
				acc_pkg::OP_SUB: return a - b;
				acc_pkg::OP_MUL: return a * b;
				acc_pkg::OP_DIV: return (b == 8'd0) ? 8'hFF : a / b;
				acc_pkg::OP_AND: return a & b;
				acc_pkg::OP_OR:  return a | b;
				acc_pkg::OP_XOR: return a ^ b;
				acc_pkg::OP_LSH: return (b >= 8'd8) ? 8'd0 : a << b;
				acc_pkg::OP_RSH: return (b >= 8'd8) ? 8'd0 : a >> b;
				default: return a;
			endcase
		endfunction

		function void execute_instr();
			logic [7:0] op, t, v;
			op = fetch_byte();
			case (op)
				acc_pkg::OP_LD:  acc = fetch_byte();
				acc_pkg::OP_SAV: dreg = acc;
				acc_pkg::OP_SWP: begin
					t = dreg; dreg = acc; acc = t;
				end
				acc_pkg::OP_ADD, acc_pkg::OP_SUB, acc_pkg::OP_MUL, acc_pkg::OP_DIV,
				acc_pkg::OP_AND, acc_pkg::OP_OR, acc_pkg::OP_XOR, acc_pkg::OP_LSH,
				acc_pkg::OP_RSH:
					acc = alu_result(op, acc, fetch_byte());
				acc_pkg::OP_INV: acc = ~acc;
				acc_pkg::OP_JMP: pc = fetch_byte() + base;
				acc_pkg::OP_JEZ: begin
					t = fetch_byte() + base; if (acc == 8'd0) pc = t;
				end
				acc_pkg::OP_JNZ: begin
					t = fetch_byte() + base; if (acc != 8'd0) pc = t;
				end
				acc_pkg::OP_MINC:  ptr = ptr + acc;
				acc_pkg::OP_MDEC:  ptr = ptr - acc;
				acc_pkg::OP_MSET:  ptr = acc;
				acc_pkg::OP_READ:  acc = mem[ptr];
				acc_pkg::OP_WRITE: mem[ptr] = acc;
				acc_pkg::OP_LDM:   acc = mem[8'(fetch_byte() + base)];
				acc_pkg::OP_SAVM:  mem[8'(fetch_byte() + base)] = acc;
				acc_pkg::OP_SWPM: begin
					t = fetch_byte() + base; v = mem[t]; mem[t] = acc; acc = v;
				end
				acc_pkg::OP_ADDM, acc_pkg::OP_SUBM, acc_pkg::OP_MULM, acc_pkg::OP_DIVM,
				acc_pkg::OP_ANDM, acc_pkg::OP_ORM, acc_pkg::OP_XORM:
					acc = alu_result(op - 8'd22, acc, mem[8'(fetch_byte() + base)]);
				acc_pkg::OP_LSHM, acc_pkg::OP_RSHM:
					acc = alu_result(op - 8'd21, acc, mem[8'(fetch_byte() + base)]);
				acc_pkg::OP_JMPM: pc = mem[8'(fetch_byte() + base)];
				acc_pkg::OP_JEZM: begin
					t = fetch_byte() + base; if (acc == 8'd0) pc = mem[t];
				end
				acc_pkg::OP_JNZM: begin
					t = fetch_byte() + base; if (acc != 8'd0) pc = mem[t];
				end
				default: run = 1'b0;
			endcase
		endfunction

		function void note_request(acc_pkg::req_t r);
			acc_pkg::rsp_t e;
			e.read_data = 8'd0;
			case (r.func)
				acc_pkg::FN_WRITE: mem[r.addr] = r.wdata;
				acc_pkg::FN_READ:  e.read_data = mem[r.addr];
				acc_pkg::FN_EXEC:  if (run) execute_instr();
				default: begin
					pc = base; run = 1'b1;
				end
			endcase
			e.acc = acc; e.data_store = dreg; e.mem_pointer = ptr;
			e.prog_counter = pc; e.running = run;
			pending.push_back(e);
		endfunction

		function void check_response(acc_pkg::rsp_t got);
			acc_pkg::rsp_t e;
			if (pending.size() == 0) begin
				report("response with nothing expected", 0, 0);
				return;
			end
			e = pending.pop_front();
			if (got.read_data !== e.read_data)
				report("read_data", got.read_data, e.read_data);
			if (got.acc !== e.acc) report("acc", got.acc, e.acc);
			if (got.data_store !== e.data_store)
				report("data_store", got.data_store, e.data_store);
			if (got.mem_pointer !== e.mem_pointer)
				report("mem_pointer", got.mem_pointer, e.mem_pointer);
			if (got.prog_counter !== e.prog_counter)
				report("prog_counter", got.prog_counter, e.prog_counter);
			if (got.running !== e.running) report("running", got.running, e.running);
		endfunction

		function void report(string what, int got, int exp);
			errors++;
			$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, exp);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	acc_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	acc_pkg::rsp_t out_data;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;

	cpu_scoreboard sb = new();

	accumulator_cpu_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Send one request after a random gap; hold until accepted
	task automatic send_request(logic [1:0] f, logic [7:0] a, logic [7:0] d);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		repeat (gap) @(negedge clk);
		in_data <= '{func: f, addr: a, wdata: d};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_request('{func: f, addr: a, wdata: d});
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic write_byte(logic [7:0] a, logic [7:0] d);
		send_request(acc_pkg::FN_WRITE, a, d);
	endtask

	// Wait for every response, then let the core settle and set the base
	task automatic set_base(logic [7:0] b);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= b;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.base = b;
	endtask

	// Load a random program at the base and run it with some restarts
	task automatic run_program(int len, int steps);
		for (int i = 0; i < len; i++) begin
			logic [7:0] v;
			case ($urandom_range(0, 9))
				0:       v = 8'($urandom_range(0, 255));
				1:       v = 8'($urandom_range(0, 9));
				2:       v = acc_pkg::OP_HLT;
				default: v = 8'($urandom_range(0, 36));
			endcase
			write_byte(sb.base + 8'(i), v);
		end
		send_request(acc_pkg::FN_RST, 8'($urandom), 8'($urandom));
		for (int i = 0; i < steps; i++) begin
			case ($urandom_range(0, 19))
				0: send_request(acc_pkg::FN_RST, 8'($urandom), 8'($urandom));
				1: send_request(acc_pkg::FN_READ, 8'($urandom), 8'($urandom));
				2: write_byte(8'($urandom), 8'($urandom));
				default: send_request(acc_pkg::FN_EXEC, 8'($urandom), 8'($urandom));
			endcase
		end
	endtask

	// Drain each response after a random stall
	initial begin
		int stall;
		forever begin
			@(negedge clk);
			if (out_valid) begin
				stall = $urandom_range(0, 12);
				repeat (stall) @(negedge clk);
				out_ready <= 1'b1;
				do @(posedge clk); while (!out_valid);
				@(negedge clk);
				out_ready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_response(out_data);
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		// directed: memory extremes, divide by zero, over-range shifts, halt and unknown opcode
		write_byte(8'h00, acc_pkg::OP_LD);   write_byte(8'h01, 8'hFF);
		write_byte(8'h02, acc_pkg::OP_DIV);  write_byte(8'h03, 8'h00);
		write_byte(8'h04, acc_pkg::OP_LSH);  write_byte(8'h05, 8'h08);
		write_byte(8'h06, acc_pkg::OP_INV);  write_byte(8'h07, acc_pkg::OP_RSHM);
		write_byte(8'h08, 8'hFF);   write_byte(8'hFF, 8'h09);
		write_byte(8'h09, 8'hC8);
		send_request(acc_pkg::FN_READ, 8'hFF, 8'h00);
		repeat (7) send_request(acc_pkg::FN_EXEC, 8'h00, 8'h00);
		send_request(acc_pkg::FN_EXEC, 8'h00, 8'h00);
		send_request(acc_pkg::FN_RST, 8'h00, 8'h00);
		write_byte(8'h00, acc_pkg::OP_HLT);
		send_request(acc_pkg::FN_EXEC, 8'h00, 8'h00);
		send_request(acc_pkg::FN_EXEC, 8'h00, 8'h00);
		send_request(acc_pkg::FN_READ, 8'h00, 8'h00);
		send_request(acc_pkg::FN_RST, 8'hFF, 8'hFF);
		// random programs over several bases including the extremes
		for (int p = 0; p < 24; p++) begin
			case (p % 6)
				0: set_base(8'h00);
				1: set_base(8'hFF);
				default: set_base(8'($urandom));
			endcase
			run_program($urandom_range(8, 24), $urandom_range(28, 48));
		end
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (sb.errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
